@@ rtl/core/tlrl_pkg.sv @@
package tlrl_pkg;

  // Field widths
  localparam int unsigned LevelW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Default bound for requested levels and clamp for the per-tick level change
  localparam int unsigned LEVEL_MAX_DEF = 4095;

  // Register reset values
  localparam logic [CfgW-1:0] STEP_INTERVAL_RST = 16'd100;
  localparam logic [CfgW-1:0] MAX_STEP_RST      = 16'd1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STEP_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STEP      = 2'd1;

  // Operation codes on the input stream
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_ATTACH  = 2'd2,
    OP_RESYNC  = 2'd3
  } op_e;

  // Classified operation held in the queue
  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_REQ_OK,
    KIND_REQ_REJ,
    KIND_ATTACH,
    KIND_RESYNC
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [TimeW-1:0]  now_ms;
    logic [LevelW-1:0] requested_level;
    logic [LevelW-1:0] present_level;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // Back end status
  typedef struct packed {
    logic busy;
    logic emit;
  } bk_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DECIDE,
    BK_DIV,
    BK_MUL_ADV,
    BK_MUL_AVAIL,
    BK_STEP
  } bk_state_e;

endpackage

@@ rtl/core/tlrl_front.sv @@
module tlrl_front #(
  parameter int unsigned LevelMax = tlrl_pkg::LEVEL_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [tlrl_pkg::TimeW-1:0]  now_ms_i,
  input  logic [tlrl_pkg::LevelW-1:0] requested_level_i,
  input  logic [tlrl_pkg::LevelW-1:0] present_level_i,
  input  logic                        device_ready_i,
  input  logic                        pop_i,
  output tlrl_pkg::head_t             head_o
);

  localparam int unsigned Depth = 2;

  tlrl_pkg::item_t entry_d;
  tlrl_pkg::item_t mem_q [Depth];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  // Classify the operation; request checks are settled here
  always_comb begin
    entry_d.now_ms          = now_ms_i;
    entry_d.requested_level = requested_level_i;
    entry_d.present_level   = present_level_i;
    case (tlrl_pkg::op_e'(op_i))
      tlrl_pkg::OP_TICK: begin
        entry_d.kind = tlrl_pkg::KIND_TICK;
      end
      tlrl_pkg::OP_REQUEST: begin
        if ((requested_level_i > tlrl_pkg::LevelW'(LevelMax)) || !device_ready_i) begin
          entry_d.kind = tlrl_pkg::KIND_REQ_REJ;
        end else begin
          entry_d.kind = tlrl_pkg::KIND_REQ_OK;
        end
      end
      tlrl_pkg::OP_ATTACH: begin
        entry_d.kind = tlrl_pkg::KIND_ATTACH;
      end
      default: begin
        entry_d.kind = tlrl_pkg::KIND_RESYNC;
      end
    endcase
  end

  assign in_ready_o = (cnt_q != 2'(Depth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

@@ rtl/core/tlrl_back.sv @@
module tlrl_back #(
  parameter int unsigned LevelMax = tlrl_pkg::LEVEL_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tlrl_pkg::head_t             head_i,
  output logic                        pop_o,
  input  logic [tlrl_pkg::CfgW-1:0]   step_interval_i,
  input  logic [tlrl_pkg::CfgW-1:0]   max_step_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [39:0]                 out_data_o,
  output tlrl_pkg::bk_stat_t          stat_o
);

  localparam int unsigned LW = tlrl_pkg::LevelW;
  localparam int unsigned TW = tlrl_pkg::TimeW;
  localparam int unsigned PW = TW + tlrl_pkg::CfgW;

  tlrl_pkg::bk_state_e state_q, state_d;
  tlrl_pkg::item_t     item_q, item_d;
  logic [LW-1:0]       target_q, target_d;
  logic                tset_q, tset_d;
  logic [TW-1:0]       last_q, last_d;
  logic [LW-1:0]       rem_q, rem_d;
  logic [TW-1:0]       quo_q, quo_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [PW-1:0]       prod_q, prod_d;
  logic                out_vld_q, out_vld_d;
  logic [39:0]         out_data_q, out_data_d;

  logic                out_free;
  logic                tick_long;
  logic                emit;
  logic [LW:0]         trial;
  logic                trial_ge;
  logic [LW-1:0]       mul_b;
  logic [PW-1:0]       mul_res;
  logic [LW-1:0]       avail;
  logic [LW-1:0]       gap;
  logic [LW-1:0]       mv;
  logic [LW-1:0]       new_target;

  assign out_free  = !out_vld_q || out_ready_i;
  assign tick_long = (item_q.kind == tlrl_pkg::KIND_TICK) &&
                     (item_q.present_level != target_q) && (step_interval_i != '0);

  // One restoring division step per cycle
  assign trial    = {rem_q, quo_q[TW-1]};
  assign trial_ge = (trial >= {1'b0, step_interval_i});

  // Shared multiplier: first the clock advance, then the allowed change
  assign mul_b   = (state_q == tlrl_pkg::BK_MUL_ADV) ? step_interval_i : max_step_i;
  assign mul_res = PW'(quo_q) * PW'(mul_b);

  // Ramp step arithmetic
  assign avail = (prod_q > PW'(LevelMax)) ? LW'(LevelMax) : prod_q[LW-1:0];
  assign gap   = (item_q.present_level < target_q) ? (target_q - item_q.present_level)
                                                   : (item_q.present_level - target_q);
  assign mv    = (gap < avail) ? gap : avail;

  assign new_target = tset_q ? target_q : item_q.present_level;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlrl_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          state_d = tlrl_pkg::BK_DECIDE;
        end
      end
      tlrl_pkg::BK_DECIDE: begin
        if (tick_long) begin
          state_d = tlrl_pkg::BK_DIV;
        end else if (out_free) begin
          state_d = tlrl_pkg::BK_IDLE;
        end
      end
      tlrl_pkg::BK_DIV: begin
        if (cnt_q == 5'd31) begin
          state_d = tlrl_pkg::BK_MUL_ADV;
        end
      end
      tlrl_pkg::BK_MUL_ADV: begin
        state_d = tlrl_pkg::BK_MUL_AVAIL;
      end
      tlrl_pkg::BK_MUL_AVAIL: begin
        state_d = tlrl_pkg::BK_STEP;
      end
      tlrl_pkg::BK_STEP: begin
        if (out_free) begin
          state_d = tlrl_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = tlrl_pkg::BK_IDLE;
      end
    endcase
  end

  // Datapath and result register
  always_comb begin
    item_d     = item_q;
    target_d   = target_q;
    tset_d     = tset_q;
    last_d     = last_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    prod_d     = prod_q;
    out_data_d = out_data_q;
    emit       = 1'b0;
    pop_o      = 1'b0;
    case (state_q)
      tlrl_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          pop_o  = 1'b1;
          item_d = head_i.item;
        end
      end
      tlrl_pkg::BK_DECIDE: begin
        if (tick_long) begin
          rem_d = '0;
          quo_d = item_q.now_ms - last_q;
          cnt_d = '0;
        end else if (out_free) begin
          emit = 1'b1;
          case (item_q.kind)
            tlrl_pkg::KIND_TICK: begin
              // Level already at target, or stepping disabled
              if (item_q.present_level == target_q) begin
                last_d = item_q.now_ms;
              end
              out_data_d = {5'd0, item_q.present_level != target_q, target_q,
                            16'd0, 1'b0, 1'b1};
            end
            tlrl_pkg::KIND_REQ_OK: begin
              target_d = item_q.requested_level;
              tset_d   = 1'b1;
              if (last_q == '0) begin
                last_d = item_q.now_ms;
              end
              out_data_d = {5'd0, item_q.present_level != item_q.requested_level,
                            item_q.requested_level, 16'd0, 1'b0, 1'b1};
            end
            tlrl_pkg::KIND_REQ_REJ: begin
              out_data_d = {5'd0, item_q.present_level != target_q, target_q,
                            16'd0, 1'b0, 1'b0};
            end
            tlrl_pkg::KIND_ATTACH: begin
              target_d   = new_target;
              tset_d     = 1'b1;
              last_d     = item_q.now_ms;
              out_data_d = {5'd0, item_q.present_level != new_target, new_target,
                            16'd0, 1'b0, 1'b1};
            end
            default: begin
              last_d     = item_q.now_ms;
              out_data_d = {5'd0, item_q.present_level != target_q, target_q,
                            16'd0, 1'b0, 1'b1};
            end
          endcase
        end
      end
      tlrl_pkg::BK_DIV: begin
        rem_d = trial_ge ? LW'(trial - {1'b0, step_interval_i}) : trial[LW-1:0];
        quo_d = {quo_q[TW-2:0], trial_ge};
        cnt_d = cnt_q + 5'd1;
      end
      tlrl_pkg::BK_MUL_ADV: begin
        prod_d = mul_res;
      end
      tlrl_pkg::BK_MUL_AVAIL: begin
        last_d = last_q + prod_q[TW-1:0];
        prod_d = mul_res;
      end
      tlrl_pkg::BK_STEP: begin
        if (out_free) begin
          emit = 1'b1;
          if (quo_q == '0) begin
            // No whole interval elapsed
            out_data_d = {5'd0, 1'b1, target_q, 16'd0, 1'b0, 1'b1};
          end else if (item_q.present_level < target_q) begin
            out_data_d = {5'd0, 1'b1, target_q, item_q.present_level + mv, 1'b1, 1'b1};
          end else begin
            out_data_d = {5'd0, 1'b1, target_q, item_q.present_level - mv, 1'b1, 1'b1};
          end
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tlrl_pkg::BK_IDLE;
      target_q  <= '0;
      tset_q    <= 1'b0;
      last_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      target_q  <= target_d;
      tset_q    <= tset_d;
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign stat_o.busy = (state_q != tlrl_pkg::BK_IDLE);
  assign stat_o.emit = emit;

endmodule

@@ rtl/core/timed_level_ramp_limiter.sv @@
// Slew-rate limiter: ramps an output level toward a stored target.
// Input stream (s_axis_*): one operation per transaction, op code in tuser.
// Result stream (m_axis_*): exactly one result per input transaction, in order.
// Config channel (cfg_*): index 0 step interval in ms, index 1 max step; always
//   ready; the user must write it only while no operation is outstanding, and
//   the block itself does not enforce this.
// A two-entry queue sits between the classifying front end and the executing
// back end, so the input side keeps accepting while a result waits.
// Request, attach, resync and ticks that do not step go from the queue to the
//   back end's item register in IDLE, then to the result register in DECIDE.
// A stepping tick divides the elapsed time serially by the step interval (DIV),
//   then uses one shared 32x16 multiplier in MUL_ADV and MUL_AVAIL, and makes
//   the ramp step in STEP. The back end handles one item at a time.
// Reset clears target, step clock, queue and result valid; config returns
//   to a 100 ms interval and a max step of 1.
// When the receiver stalls, the result is held; the back end waits with the
//   next result and the queue fills, then s_axis_tready drops.
module timed_level_ramp_limiter #(
  parameter int unsigned LevelMax = tlrl_pkg::LEVEL_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] now_ms, [47:32] requested_level, [63:48] present_level,
  // [64] device_ready, [71:65] zero
  input  logic [71:0]                       s_axis_tdata,
  // [1:0] op
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] accepted, [1] drive_valid, [17:2] drive_level, [33:18] target_level,
  // [34] transitioning, [39:35] zero
  output logic [39:0]                       m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tlrl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tlrl_pkg::CfgW-1:0]         cfg_data_i
);

  logic [tlrl_pkg::CfgW-1:0] step_interval_q, max_step_q;
  tlrl_pkg::head_t           head;
  tlrl_pkg::bk_stat_t        bk_stat;
  logic                      pop;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_interval_q <= tlrl_pkg::STEP_INTERVAL_RST;
      max_step_q      <= tlrl_pkg::MAX_STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tlrl_pkg::CFG_STEP_INTERVAL: step_interval_q <= cfg_data_i;
        tlrl_pkg::CFG_MAX_STEP:      max_step_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tlrl_front #(
    .LevelMax (LevelMax)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .op_i              (s_axis_tuser),
    .now_ms_i          (s_axis_tdata[31:0]),
    .requested_level_i (s_axis_tdata[47:32]),
    .present_level_i   (s_axis_tdata[63:48]),
    .device_ready_i    (s_axis_tdata[64]),
    .pop_i             (pop),
    .head_o            (head)
  );

  tlrl_back #(
    .LevelMax (LevelMax)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .step_interval_i (step_interval_q),
    .max_step_i      (max_step_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .stat_o          (bk_stat)
  );

`ifndef SYNTHESIS
  // A new result never overwrites one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // A driven level only comes with an accepted operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
    else $error("drive without accept");

  // A fresh result only appears after the back end was working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(bk_stat.busy))
    else $error("result from idle back end");

  // Input backpressure only when the queue holds items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> head.valid)
    else $error("stall with empty queue");
`endif

endmodule
